### src/blrle_pkg.sv
// Shared types, constants and controller codes for the bit-plane line RLE encoder.
// Used by blrle_ctrl, blrle_dp, the top level and the checker.
`default_nettype none
package blrle_pkg;

  localparam int MAX_RUN_WORDS_DEF     = 63;
  localparam int MAX_LITERAL_WORDS_DEF = 127;

  localparam int WORD_W  = 16;
  localparam int CHUNK_W = 64;
  localparam int BYTES_W = 4;

  localparam logic [7:0]         LIT_MARK    = 8'h80;
  localparam logic [BYTES_W-1:0] CHUNK_FULL  = 4'd8;
  localparam logic [BYTES_W-1:0] LAST_WORD_B = 4'd6;
  localparam logic [BYTES_W-1:0] RUN_SHORT_B = 4'd1;
  localparam logic [BYTES_W-1:0] RUN_LONG_B  = 4'd4;
  localparam logic [BYTES_W-1:0] HDR_B       = 4'd2;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              line_end;
  } in_beat_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic [BYTES_W-1:0] chunk_bytes;
    logic               last_of_run;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_EQ_CHK,
    S_CLR_HELD,
    S_LOAD_NEW,
    S_TAIL,
    S_FINAL,
    S_CLEAR,
    S_RUN,
    S_LIT_HDR,
    S_LIT_DATA,
    S_LIT_EMIT,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic ready;
    logic load_new;
    logic bump_run;
    logic push;
    logic clr_held;
    logic lit_start;
    logic lit_append;
    logic lit_clear;
    logic emit_run;
    logic emit_lit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic held_valid;
    logic word_eq;
    logic run_ge2;
    logic run_max;
    logic lit_nz;
    logic push_full;
    logic item_last;
    logic chunk_done;
    logic ptr_end;
    logic emit_ok;
  } dp_sts_t;

endpackage
`default_nettype wire

### src/blrle_ctrl.sv
// Controller for the bit-plane line RLE encoder: sequences one input beat
// through run, push and literal-flush steps. Depends on blrle_pkg.
`default_nettype none
module blrle_ctrl
  import blrle_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;
  ctrl_state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // Next state and return point
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.held_valid) begin
          state_nxt = S_TAIL;
        end else if (sts.word_eq) begin
          if (!sts.run_ge2 && sts.lit_nz) begin
            state_nxt = S_LIT_HDR;
            ret_nxt   = S_EQ_CHK;
          end else begin
            state_nxt = S_EQ_CHK;
          end
        end else if (sts.run_ge2) begin
          state_nxt = S_RUN;
          ret_nxt   = S_LOAD_NEW;
        end else if (sts.push_full) begin
          state_nxt = S_LIT_HDR;
          ret_nxt   = S_LOAD_NEW;
        end else begin
          state_nxt = S_LOAD_NEW;
        end
      end
      S_EQ_CHK: begin
        if (sts.run_max) begin
          state_nxt = S_RUN;
          ret_nxt   = S_CLR_HELD;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_CLR_HELD: state_nxt = S_TAIL;
      S_LOAD_NEW: state_nxt = S_TAIL;
      S_TAIL: begin
        if (!sts.item_last) begin
          state_nxt = S_DONE;
        end else if (sts.held_valid && sts.run_ge2) begin
          state_nxt = S_RUN;
          ret_nxt   = S_FINAL;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts.lit_nz) begin
          state_nxt = S_LIT_HDR;
          ret_nxt   = S_CLEAR;
        end else begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: state_nxt = S_DONE;
      S_RUN: begin
        if (sts.emit_ok) state_nxt = ret_r;
      end
      S_LIT_HDR: state_nxt = S_LIT_DATA;
      S_LIT_DATA: begin
        if (sts.chunk_done) state_nxt = S_LIT_EMIT;
      end
      S_LIT_EMIT: begin
        if (sts.emit_ok) state_nxt = sts.ptr_end ? ret_r : S_LIT_DATA;
      end
      S_DONE: begin
        if (sts.emit_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.ready = 1'b1;
      S_EVAL: begin
        if (!sts.held_valid) begin
          cmd.load_new = 1'b1;
        end else if (sts.word_eq) begin
          cmd.bump_run = 1'b1;
        end else if (!sts.run_ge2) begin
          cmd.push = 1'b1;
        end
      end
      S_EQ_CHK:   cmd = '0;
      S_CLR_HELD: cmd.clr_held = 1'b1;
      S_LOAD_NEW: cmd.load_new = 1'b1;
      S_TAIL: begin
        if (sts.item_last && sts.held_valid && !sts.run_ge2) cmd.push = 1'b1;
      end
      S_FINAL:    cmd = '0;
      S_CLEAR:    cmd.clr_held = 1'b1;
      S_RUN:      cmd.emit_run = sts.emit_ok;
      S_LIT_HDR:  cmd.lit_start = 1'b1;
      S_LIT_DATA: cmd.lit_append = 1'b1;
      S_LIT_EMIT: begin
        cmd.emit_lit  = sts.emit_ok;
        cmd.lit_clear = sts.emit_ok && sts.ptr_end;
      end
      S_DONE:     cmd.finish = sts.emit_ok;
      default:    cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### src/blrle_dp.sv
// Datapath for the bit-plane line RLE encoder: held word, run counter,
// literal store, chunk assembly and the output stage. Depends on blrle_pkg.
`default_nettype none
module blrle_dp
  import blrle_pkg::*;
#(
  parameter int MAX_RUN_WORDS     = MAX_RUN_WORDS_DEF,
  parameter int MAX_LITERAL_WORDS = MAX_LITERAL_WORDS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_beat_t  in_data,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_beat_t      out_data,
  input  wire dp_cmd_t   cmd,
  output dp_sts_t        sts
);

  localparam int RUN_W = $clog2(MAX_RUN_WORDS + 1);
  localparam int CNT_W = $clog2(MAX_LITERAL_WORDS + 1);
  localparam int IDX_W = (MAX_LITERAL_WORDS > 1) ? $clog2(MAX_LITERAL_WORDS) : 1;

  in_beat_t            item_r;
  logic [WORD_W-1:0]   held_r,  held_nxt;
  logic                hv_r,    hv_nxt;
  logic [RUN_W-1:0]    run_r,   run_nxt;
  logic [CNT_W-1:0]    lcnt_r,  lcnt_nxt;
  logic [CNT_W-1:0]    ptr_r,   ptr_nxt;
  logic [CHUNK_W-1:0]  asm_r,   asm_nxt;
  logic [BYTES_W-1:0]  abytes_r, abytes_nxt;
  logic [WORD_W-1:0]   rd_data_r;
  logic [WORD_W-1:0]   store_r [MAX_LITERAL_WORDS];

  logic [CHUNK_W-1:0]  pend_chunk_r;
  logic [BYTES_W-1:0]  pend_bytes_r;
  logic                pend_v_r;
  logic                out_valid_r;
  out_beat_t           out_r;

  logic                take;
  logic                out_free;
  logic                emit;
  logic [CHUNK_W-1:0]  run_chunk;
  logic [BYTES_W-1:0]  run_bytes;
  logic [7:0]          two_k;
  logic [CHUNK_W-1:0]  new_chunk;
  logic [BYTES_W-1:0]  new_bytes;

  assign take     = in_valid && cmd.ready;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cmd.emit_run || cmd.emit_lit;

  // Status to the controller
  always_comb begin
    sts.held_valid = hv_r;
    sts.word_eq    = (item_r.word == held_r);
    sts.run_ge2    = (run_r >= RUN_W'(2));
    sts.run_max    = (run_r >= RUN_W'(MAX_RUN_WORDS));
    sts.lit_nz     = (lcnt_r != '0);
    sts.push_full  = (lcnt_r == CNT_W'(MAX_LITERAL_WORDS - 1));
    sts.item_last  = item_r.line_end;
    sts.chunk_done = (abytes_r == LAST_WORD_B) || ((ptr_r + CNT_W'(1)) == lcnt_r);
    sts.ptr_end    = (ptr_r == lcnt_r);
    sts.emit_ok    = !pend_v_r || out_free;
  end

  // Run code: one byte for all-zero or all-ones, else four bytes
  always_comb begin
    two_k = 8'({run_r, 1'b0});
    if (held_r == '0) begin
      run_chunk = {1'b0, two_k[6:0], 56'd0};
      run_bytes = RUN_SHORT_B;
    end else if (held_r == '1) begin
      run_chunk = {1'b1, two_k[6:0], 56'd0};
      run_bytes = RUN_SHORT_B;
    end else begin
      run_chunk = {8'd0, 8'(run_r), held_r, 32'd0};
      run_bytes = RUN_LONG_B;
    end
  end

  assign new_chunk = cmd.emit_lit ? asm_r    : run_chunk;
  assign new_bytes = cmd.emit_lit ? abytes_r : run_bytes;

  // Held word, run count, literal count and assembly
  always_comb begin
    held_nxt   = held_r;
    hv_nxt     = hv_r;
    run_nxt    = run_r;
    lcnt_nxt   = lcnt_r;
    ptr_nxt    = ptr_r;
    asm_nxt    = asm_r;
    abytes_nxt = abytes_r;
    if (cmd.load_new) begin
      held_nxt = item_r.word;
      hv_nxt   = 1'b1;
      run_nxt  = RUN_W'(1);
    end
    if (cmd.bump_run) begin
      run_nxt = (run_r >= RUN_W'(2)) ? run_r + RUN_W'(1) : RUN_W'(2);
    end
    if (cmd.clr_held) begin
      hv_nxt  = 1'b0;
      run_nxt = '0;
    end
    if (cmd.push) lcnt_nxt = lcnt_r + CNT_W'(1);
    if (cmd.lit_start) begin
      asm_nxt    = {LIT_MARK, 8'({lcnt_r, 1'b0}), 48'd0};
      abytes_nxt = HDR_B;
      ptr_nxt    = '0;
    end
    if (cmd.lit_append) begin
      asm_nxt    = asm_r | ({rd_data_r, 48'd0} >> {abytes_r, 3'b000});
      abytes_nxt = abytes_r + BYTES_W'(2);
      ptr_nxt    = ptr_r + CNT_W'(1);
    end
    if (cmd.emit_lit) begin
      asm_nxt    = '0;
      abytes_nxt = '0;
    end
    if (cmd.lit_clear) lcnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r     <= 1'b0;
      run_r    <= '0;
      lcnt_r   <= '0;
      ptr_r    <= '0;
      abytes_r <= '0;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hv_r     <= hv_nxt;
      run_r    <= run_nxt;
      lcnt_r   <= lcnt_nxt;
      ptr_r    <= ptr_nxt;
      abytes_r <= abytes_nxt;
      if (emit) begin
        pend_v_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_v_r <= 1'b0;
      end
      if ((emit || cmd.finish) && pend_v_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) item_r <= in_data;
    held_r <= held_nxt;
    asm_r  <= asm_nxt;
    if (emit) begin
      pend_chunk_r <= new_chunk;
      pend_bytes_r <= new_bytes;
    end
    if ((emit || cmd.finish) && pend_v_r) begin
      out_r.chunk       <= pend_chunk_r;
      out_r.chunk_bytes <= pend_bytes_r;
      out_r.last_of_run <= cmd.finish;
    end
  end

  // Literal store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) store_r[lcnt_r[IDX_W-1:0]] <= held_r;
    rd_data_r <= store_r[ptr_nxt[IDX_W-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### src/bitplane_line_run_length_encoder.sv
// Bit-plane line run-length encoder, top level: controller plus datapath.
// Depends on blrle_pkg, blrle_ctrl and blrle_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one 16-bit word of a
//   plane line per beat, with line_end on the last word of the line.
//   Output channel (out_valid / out_stall / out_data) carries code chunks of
//   one to eight bytes, first byte in the top byte of chunk; last_of_run marks
//   the final chunk caused by an input beat. A beat may cause no chunk at all.
//   Throughput: one beat at a time. A beat that only updates the run or the
//   literal store passes the evaluate and tail states; a line end adds the
//   final and clear states, a run code the run state, and a literal flush a
//   header step, then reads the buffered words through the single read port
//   of the literal store and emits each chunk as it fills. The last chunk of a
//   beat reaches out_data in the cycle after the controller finishes the beat,
//   as each chunk waits in a holding register until it is known whether another follows.
//   Reset (rst_n low, synchronous) empties the run and literal state and the
//   output stage; the literal store itself is not cleared.
//   When the receiver stalls, out_data holds; one further chunk waits in the
//   holding register and the controller then waits, so in_stall stays high.
`default_nettype none
module bitplane_line_run_length_encoder
  import blrle_pkg::*;
#(
  parameter int MAX_RUN_WORDS     = MAX_RUN_WORDS_DEF,
  parameter int MAX_LITERAL_WORDS = MAX_LITERAL_WORDS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller takes a beat only from its idle state.
  assign in_stall = !cmd.ready;

  blrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  blrle_dp #(
    .MAX_RUN_WORDS     (MAX_RUN_WORDS),
    .MAX_LITERAL_WORDS (MAX_LITERAL_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

### src/blrle_chk.sv
// Port-level checker for the bit-plane line RLE encoder, bound to the top level.
// Depends on blrle_pkg.
`default_nettype none
module blrle_chk
  import blrle_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_beat_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_data
);

  // Hold a stalled beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.chunk_bytes != 4'd0 && out_data.chunk_bytes <= CHUNK_FULL)
    else $error("chunk byte count out of range");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second beat while working");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind bitplane_line_run_length_encoder blrle_chk u_chk (.*);
`default_nettype wire

### dv/bitplane_line_run_length_encoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitplane_line_run_length_encoder: a directed table, then random
// plane lines through four idle/stall phases, checked against a built-in encoder predictor.
// Depends on blrle_pkg and bitplane_line_run_length_encoder.
module bitplane_line_run_length_encoder_test;
  import blrle_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The limit
  // leaves a wide margin even for the slowest beat, a full literal flush under
  // heavy receiver stall.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles to hold after the last expected chunk: covers a beat still being
  // processed that produces no chunk, plus the one-deep output holding register.
  localparam int SETTLE_CYCLES  = 40;
  localparam int WORDS_PER_PHASE = 20;
  localparam int NUM_PHASES      = 4;
  localparam int MAX_PRINTED     = 50;
  // Flag bit of a run code over all-ones words.
  localparam logic [7:0] ONES_FLAG = 8'h80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  bitplane_line_run_length_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Encoder predictor: own copy of the line state.
  // ---------------------------------------------------------------------------
  logic [15:0] pend_word;
  bit          pend_ok;
  int unsigned pend_run;
  logic [15:0] lit_words [MAX_LITERAL_WORDS_DEF];
  int unsigned lit_n;

  logic [7:0]  code_buf [2 + 2 * MAX_LITERAL_WORDS_DEF];
  int          code_len;

  out_beat_t   step_chunks[$];   // chunks caused by the beat being predicted
  out_beat_t   chunks_due[$];    // chunks still owed by the encoder, oldest first

  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          phase_words;
  int          idle_cycles = 0;

  // Cut the code in code_buf into chunks of up to eight bytes, first byte on top.
  function automatic void cut_code();
    out_beat_t b;
    int pos, take;
    pos = 0;
    while (pos < code_len) begin
      take = (code_len - pos > 8) ? 8 : code_len - pos;
      b = '0;
      for (int i = 0; i < take; i++) b.chunk[CHUNK_W-1-8*i -: 8] = code_buf[pos+i];
      b.chunk_bytes = BYTES_W'(take);
      step_chunks.push_back(b);
      pos += take;
    end
  endfunction

  function automatic void emit_run();
    logic [7:0] twice_k;
    twice_k = 8'(2 * pend_run) & 8'h7F;
    if (pend_word == 16'h0000) begin
      code_buf[0] = twice_k;
      code_len = 1;
    end else if (pend_word == 16'hFFFF) begin
      code_buf[0] = ONES_FLAG | twice_k;
      code_len = 1;
    end else begin
      code_buf[0] = 8'h00;
      code_buf[1] = 8'(pend_run);
      code_buf[2] = pend_word[15:8];
      code_buf[3] = pend_word[7:0];
      code_len = 4;
    end
    cut_code();
  endfunction

  function automatic void emit_literal();
    if (lit_n == 0) return;
    code_buf[0] = LIT_MARK;
    code_buf[1] = 8'(2 * lit_n);
    for (int i = 0; i < lit_n; i++) begin
      code_buf[2 + 2*i] = lit_words[i][15:8];
      code_buf[3 + 2*i] = lit_words[i][7:0];
    end
    code_len = 2 + 2 * lit_n;
    cut_code();
    lit_n = 0;
  endfunction

  function automatic void buffer_literal(input logic [15:0] w);
    if (lit_n < MAX_LITERAL_WORDS_DEF) begin
      lit_words[lit_n] = w;
      lit_n++;
    end
    // Flush as soon as the buffer is full.
    if (lit_n >= MAX_LITERAL_WORDS_DEF) emit_literal();
  endfunction

  // Advance the line state by one word; leave the chunks it causes in step_chunks.
  function automatic void encode_word(input logic [15:0] w, input logic le);
    step_chunks.delete();
    if (!pend_ok) begin
      pend_word = w;
      pend_ok   = 1'b1;
      pend_run  = 1;
    end else if (w == pend_word) begin
      // A run starts: flush any pending literal first to keep word order.
      if (pend_run < 2) begin
        emit_literal();
        pend_run = 2;
      end else begin
        pend_run++;
      end
      // Run at its maximum: send it now, next word starts fresh.
      if (pend_run >= MAX_RUN_WORDS_DEF) begin
        emit_run();
        pend_ok  = 1'b0;
        pend_run = 0;
      end
    end else begin
      if (pend_run >= 2) emit_run();
      else buffer_literal(pend_word);
      pend_word = w;
      pend_run  = 1;
    end
    // Line end: close everything; a lone held word joins the literal.
    if (le) begin
      if (pend_ok) begin
        if (pend_run >= 2) emit_run();
        else buffer_literal(pend_word);
      end
      emit_literal();
      pend_ok  = 1'b0;
      pend_run = 0;
    end
    if (step_chunks.size() != 0) step_chunks[step_chunks.size()-1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Drive at the falling edge, sample the handshake at the rising edge.
  // Each call starts just after a rising edge and returns at the edge of acceptance.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [15:0] w, input logic le);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{word: w, line_end: le};
    do @(posedge clk); while (in_stall);
    phase_words++;
  endtask

  // Send one word and queue every chunk the predictor says it causes.
  task automatic feed_word(input logic [15:0] w, input logic le);
    send_word(w, le);
    encode_word(w, le);
    foreach (step_chunks[i]) chunks_due.push_back(step_chunks[i]);
  endtask

  // Hold the sender until every owed chunk has arrived, then let the encoder settle.
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chunks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Build one plane line from runs, literals and noise, then send it.
  // with_extremes prepends a run past the maximum and a literal past the buffer size.
  task automatic send_line(input bit with_extremes);
    logic [15:0] words[$];
    logic [15:0] v;
    int segs, kind, len;
    if (with_extremes) begin
      repeat (MAX_RUN_WORDS_DEF + 2) words.push_back(16'hFFFF);
      repeat (MAX_LITERAL_WORDS_DEF + 1) begin
        v = 16'($urandom);
        if (v == words[words.size()-1]) v = ~v;
        words.push_back(v);
      end
    end
    segs = $urandom_range(1, 4);
    repeat (segs) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // Run of equal words; now and then one that hits the maximum.
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 66) : $urandom_range(2, 8);
        case ($urandom_range(0, 2))
          0:       v = 16'h0000;
          1:       v = 16'hFFFF;
          default: v = 16'($urandom);
        endcase
        repeat (len) words.push_back(v);
      end else if (kind < 8) begin
        // Literal: adjacent words differ; now and then one that fills the buffer.
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(124, 130) : $urandom_range(1, 6);
        repeat (len) begin
          v = 16'($urandom);
          if (words.size() != 0 && v == words[words.size()-1]) v = ~v;
          words.push_back(v);
        end
      end else begin
        // Noise from a small set so accidental short runs appear.
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 3))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = (words.size() != 0) ? words[words.size()-1] : 16'h00FF;
            default: v = 16'($urandom);
          endcase
          words.push_back(v);
        end
      end
    end
    foreach (words[i]) feed_word(words[i], i == words.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows with fixed_exp carry their expectation typed in
  // (zero or one chunk); the rest are checked against the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [15:0]        word;
    logic               line_end;
    logic               fixed_exp;
    logic               has_chunk;
    logic [CHUNK_W-1:0] chunk;
    logic [BYTES_W-1:0] nbytes;
  } plan_row_t;

  plan_row_t plan_rows[$];

  task automatic add_row(input logic [15:0] w, input logic le, input logic fixed,
                         input logic has, input logic [CHUNK_W-1:0] c,
                         input logic [BYTES_W-1:0] n);
    plan_rows.push_back('{word: w, line_end: le, fixed_exp: fixed, has_chunk: has,
                          chunk: c, nbytes: n});
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at random at the falling edge; check each accepted chunk.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chunks_due.size() == 0) begin
        report_mismatch($sformatf("unexpected chunk %h (%0d bytes)",
                                  out_data.chunk, out_data.chunk_bytes));
      end else begin
        want = chunks_due.pop_front();
        if (out_data.chunk !== want.chunk)
          report_mismatch($sformatf("chunk %h, want %h", out_data.chunk, want.chunk));
        if (out_data.chunk_bytes !== want.chunk_bytes)
          report_mismatch($sformatf("chunk_bytes %0d, want %0d",
                                    out_data.chunk_bytes, want.chunk_bytes));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, want %b",
                                    out_data.last_of_run, want.last_of_run));
      end
    end
  end

  // Watchdog: count cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("bitplane_line_run_length_encoder_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  int phase_idle [NUM_PHASES] = '{0, 46, 0, 18};
  int phase_stall[NUM_PHASES] = '{0, 0, 46, 18};

  initial begin
    pend_word = '0;
    pend_ok   = 1'b0;
    pend_run  = 0;
    lit_n     = 0;

    // Hold reset at the start, then release it at a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // First word after reset causes nothing; a zero pair closed by line end.
    add_row(16'h0000, 1'b0, 1'b1, 1'b0, '0, '0);
    add_row(16'h0000, 1'b1, 1'b1, 1'b1, 64'h0400_0000_0000_0000, RUN_SHORT_B);
    // All-ones pair.
    add_row(16'hFFFF, 1'b0, 1'b1, 1'b0, '0, '0);
    add_row(16'hFFFF, 1'b1, 1'b1, 1'b1, 64'h8400_0000_0000_0000, RUN_SHORT_B);
    // Lone word at line end becomes a one-word literal.
    add_row(16'h1234, 1'b1, 1'b1, 1'b1, 64'h8002_1234_0000_0000, RUN_LONG_B);
    // Patterned run of three.
    add_row(16'hA5A5, 1'b0, 1'b1, 1'b0, '0, '0);
    add_row(16'hA5A5, 1'b0, 1'b1, 1'b0, '0, '0);
    add_row(16'hA5A5, 1'b1, 1'b1, 1'b1, 64'h0003_A5A5_0000_0000, RUN_LONG_B);
    // Literal flushed by a run start, then run and lone word at line end.
    add_row(16'h0001, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'h0002, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'h0003, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'h0003, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'h8000, 1'b1, 1'b0, 1'b0, '0, '0);
    // Alternating bit patterns into a literal that spans two chunks.
    add_row(16'h5555, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'hAAAA, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'hFFFE, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'h7FFF, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'h0000, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'h0000, 1'b0, 1'b0, 1'b0, '0, '0);
    // Zero run closed by an all-ones run closed at line end.
    add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'hFFFF, 1'b1, 1'b0, 1'b0, '0, '0);
    // Patterned pair closed by line end.
    add_row(16'hC3C3, 1'b0, 1'b0, 1'b0, '0, '0);
    add_row(16'hC3C3, 1'b1, 1'b0, 1'b0, '0, '0);

    phase_words = 0;
    foreach (plan_rows[i]) begin
      send_word(plan_rows[i].word, plan_rows[i].line_end);
      encode_word(plan_rows[i].word, plan_rows[i].line_end);
      if (plan_rows[i].fixed_exp) begin
        if (plan_rows[i].has_chunk)
          chunks_due.push_back('{chunk: plan_rows[i].chunk,
                                 chunk_bytes: plan_rows[i].nbytes,
                                 last_of_run: 1'b1});
      end else begin
        foreach (step_chunks[j]) chunks_due.push_back(step_chunks[j]);
      end
    end
    drain_outputs();

    // Random lines, one phase per idle/stall mix. The first line carries the
    // maximum run and a full literal buffer.
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = phase_idle[p];
      stall_pct     = phase_stall[p];
      phase_words   = 0;
      while (phase_words < WORDS_PER_PHASE) begin
        send_line(p == 0 && phase_words == 0);
        // Now and then hold the sender until the encoder has caught up.
        if ($urandom_range(0, 7) == 0) drain_outputs();
      end
      drain_outputs();
    end

    stall_pct = 0;
    drain_outputs();
    if (mismatches == 0) begin
      $display("bitplane_line_run_length_encoder_test passed");
    end else begin
      $display("bitplane_line_run_length_encoder_test failed");
    end
    $finish;
  end

endmodule
